/* sv/ycq_pkg.sv */
// Package for the YCbCr 2x2 quad to RGB888 converter.
// Holds the register map, the payload structs and the saturation helper.
// No dependencies.
package ycq_pkg;

   localparam int unsigned SAMPLE_W = 8;
   // Signed width of one chroma or luma product (9 x 9 bits).
   localparam int unsigned PROD_W   = 18;
   // Signed width of a chroma offset or a scaled luma after the shift.
   localparam int unsigned OFFSET_W = 11;
   // Signed width of a luma plus offset sum before clamping.
   localparam int unsigned SUM_W    = 12;
   localparam int unsigned CSR_IDX_W = 3;

   localparam int unsigned CHROMA_SHIFT = 6;
   localparam int unsigned GREEN_SHIFT  = 7;
   localparam int unsigned LUMA_SHIFT   = 7;
   localparam logic signed [SAMPLE_W:0] CHROMA_BIAS = 9'sd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CB_BLUE_FACTOR   = 3'd0,
      CSR_CR_RED_FACTOR    = 3'd1,
      CSR_CB_GREEN_FACTOR  = 3'd2,
      CSR_CR_GREEN_FACTOR  = 3'd3,
      CSR_LUMA_GAIN        = 3'd4,
      CSR_LUMA_BLACK_LEVEL = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] cb_blue_factor;
      logic [SAMPLE_W-1:0] cr_red_factor;
      logic [SAMPLE_W-1:0] cb_green_factor;
      logic [SAMPLE_W-1:0] cr_green_factor;
      logic [SAMPLE_W-1:0] luma_gain;
      logic [SAMPLE_W-1:0] luma_black_level;
   } csr_type;

   // JPEG full range defaults.
   localparam csr_type CSR_RESET = '{
      cb_blue_factor:   8'd113,
      cr_red_factor:    8'd90,
      cb_green_factor:  8'd44,
      cr_green_factor:  8'd91,
      luma_gain:        8'd128,
      luma_black_level: 8'd0
   };

   typedef struct packed {
      logic [SAMPLE_W-1:0] luma_top_left;
      logic [SAMPLE_W-1:0] luma_top_right;
      logic [SAMPLE_W-1:0] luma_bottom_left;
      logic [SAMPLE_W-1:0] luma_bottom_right;
      logic [SAMPLE_W-1:0] chroma_red;
      logic [SAMPLE_W-1:0] chroma_blue;
   } quad_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] red_off;
      logic signed [OFFSET_W-1:0] green_off;
      logic signed [OFFSET_W-1:0] blue_off;
   } chroma_off_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
   } rgb_type;

   // Clamps a signed sum to 0..255.
   function automatic logic [SAMPLE_W-1:0] clamp_u8(input logic signed [SUM_W-1:0] value);
      logic [SAMPLE_W-1:0] result;
      if (value[SUM_W-1]) begin
         result = '0;
      end else if (|value[SUM_W-2:SAMPLE_W]) begin
         result = '1;
      end else begin
         result = value[SAMPLE_W-1:0];
      end
      return result;
   endfunction

endpackage

/* sv/ycq_chroma.sv */
// Chroma offset unit: removes the 128 bias from Cr and Cb and forms the
// red, green and blue offsets shared by the four pixels of a quad.
// Depends on ycq_pkg.
module ycq_chroma (
   input  logic [ycq_pkg::SAMPLE_W-1:0] chroma_red,
   input  logic [ycq_pkg::SAMPLE_W-1:0] chroma_blue,
   input  ycq_pkg::csr_type             csr,
   output ycq_pkg::chroma_off_type      offsets
);
   import ycq_pkg::*;

   logic signed [SAMPLE_W:0] v_centred;
   logic signed [SAMPLE_W:0] u_centred;
   logic signed [PROD_W-1:0] blue_prod;
   logic signed [PROD_W-1:0] red_prod;
   logic signed [PROD_W-1:0] green_sum;
   logic signed [PROD_W-1:0] blue_shr;
   logic signed [PROD_W-1:0] red_shr;
   logic signed [PROD_W-1:0] green_shr;

   assign v_centred = $signed({1'b0, chroma_red}) - CHROMA_BIAS;
   assign u_centred = $signed({1'b0, chroma_blue}) - CHROMA_BIAS;

   assign blue_prod = PROD_W'($signed({1'b0, csr.cb_blue_factor})) * PROD_W'(u_centred);
   assign red_prod  = PROD_W'($signed({1'b0, csr.cr_red_factor})) * PROD_W'(v_centred);
   assign green_sum = PROD_W'($signed({1'b0, csr.cb_green_factor})) * PROD_W'(u_centred)
                    + PROD_W'($signed({1'b0, csr.cr_green_factor})) * PROD_W'(v_centred);

   // Arithmetic shifts give the floor towards minus infinity.
   assign blue_shr  = blue_prod >>> CHROMA_SHIFT;
   assign red_shr   = red_prod >>> CHROMA_SHIFT;
   assign green_shr = green_sum >>> GREEN_SHIFT;

   assign offsets.blue_off  = blue_shr[OFFSET_W-1:0];
   assign offsets.red_off   = red_shr[OFFSET_W-1:0];
   assign offsets.green_off = green_shr[OFFSET_W-1:0];

endmodule

/* sv/ycq_pixel.sv */
// One pixel lane: scales a luma sample, adds the shared chroma offsets and
// clamps each channel to 8 bits.
// Depends on ycq_pkg.
module ycq_pixel (
   input  logic [ycq_pkg::SAMPLE_W-1:0] luma,
   input  logic [ycq_pkg::SAMPLE_W-1:0] luma_gain,
   input  logic [ycq_pkg::SAMPLE_W-1:0] luma_black_level,
   input  ycq_pkg::chroma_off_type      offsets,
   output ycq_pkg::rgb_type             rgb
);
   import ycq_pkg::*;

   logic signed [SAMPLE_W:0]   y_diff;
   logic signed [PROD_W-1:0]   y_scaled;
   logic signed [PROD_W-1:0]   y_shr;
   logic signed [OFFSET_W-1:0] y_lin;
   logic signed [SUM_W-1:0]    red_sum;
   logic signed [SUM_W-1:0]    green_sum;
   logic signed [SUM_W-1:0]    blue_sum;

   // Luma below the black level goes negative and is clamped later.
   assign y_diff   = $signed({1'b0, luma}) - $signed({1'b0, luma_black_level});
   assign y_scaled = PROD_W'($signed({1'b0, luma_gain})) * PROD_W'(y_diff);
   assign y_shr    = y_scaled >>> LUMA_SHIFT;
   assign y_lin    = y_shr[OFFSET_W-1:0];

   assign red_sum   = {y_lin[OFFSET_W-1], y_lin} + {offsets.red_off[OFFSET_W-1], offsets.red_off};
   assign green_sum = {y_lin[OFFSET_W-1], y_lin}
                    - {offsets.green_off[OFFSET_W-1], offsets.green_off};
   assign blue_sum  = {y_lin[OFFSET_W-1], y_lin}
                    + {offsets.blue_off[OFFSET_W-1], offsets.blue_off};

   assign rgb.red   = clamp_u8(red_sum);
   assign rgb.green = clamp_u8(green_sum);
   assign rgb.blue  = clamp_u8(blue_sum);

endmodule

/* sv/ycbcr_quad_to_rgb888.sv */
// Top level of the YCbCr 4:2:0 quad to RGB888 converter.
// Depends on ycq_pkg, ycq_chroma and ycq_pixel.
//
// Usage:
//   An item is one 2x2 quad: four luma bytes and one shared Cr/Cb pair.
//   It is taken at a rising edge with start high and busy low. busy is
//   high only while reset is held, so a quad can be offered every cycle.
//   The result, twelve clamped R,G,B bytes, is shown on the rsp_ ports once
//   the item has passed the input register and the result register, marked
//   by rsp_valid for exactly one cycle.
//   Throughput is one item per cycle. The path is one input register, then
//   a single pass of multiply, add and clamp logic into the result register.
//   The receiver cannot stall; it must take every result in the cycle it
//   is shown.
//   The six factor registers are written through csr_write_enable, csr_index
//   and csr_write_data; the user must do so only while no item is in flight,
//   which the block does not enforce. Writes to indexes beyond the register
//   map are ignored. Reset is synchronous: it drops any item in flight and
//   restores the JPEG full range factors.
module ycbcr_quad_to_rgb888 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ycq_pkg::SAMPLE_W-1:0]  req_luma_top_left,
   input  logic [ycq_pkg::SAMPLE_W-1:0]  req_luma_top_right,
   input  logic [ycq_pkg::SAMPLE_W-1:0]  req_luma_bottom_left,
   input  logic [ycq_pkg::SAMPLE_W-1:0]  req_luma_bottom_right,
   input  logic [ycq_pkg::SAMPLE_W-1:0]  req_chroma_red,
   input  logic [ycq_pkg::SAMPLE_W-1:0]  req_chroma_blue,
   output logic                          rsp_valid,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_red_top_left,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_green_top_left,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_blue_top_left,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_red_top_right,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_green_top_right,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_blue_top_right,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_red_bottom_left,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_green_bottom_left,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_blue_bottom_left,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_red_bottom_right,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_green_bottom_right,
   output logic [ycq_pkg::SAMPLE_W-1:0]  rsp_blue_bottom_right,
   input  logic                          csr_write_enable,
   input  logic [ycq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ycq_pkg::SAMPLE_W-1:0]  csr_write_data
);
   import ycq_pkg::*;

   localparam int unsigned LANES = 4;

   csr_type        csr_ff;
   csr_type        csr_in;
   quad_type       quad_ff;
   quad_type       quad_in;
   logic           in_valid_ff;
   logic           in_valid_in;
   logic           out_valid_ff;
   chroma_off_type offsets;
   logic [SAMPLE_W-1:0] lane_luma [LANES];
   rgb_type        rgb_in [LANES];
   rgb_type        rgb_ff [LANES];
   logic           accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // Register map decode.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CB_BLUE_FACTOR:   csr_in.cb_blue_factor   = csr_write_data;
            CSR_CR_RED_FACTOR:    csr_in.cr_red_factor    = csr_write_data;
            CSR_CB_GREEN_FACTOR:  csr_in.cb_green_factor  = csr_write_data;
            CSR_CR_GREEN_FACTOR:  csr_in.cr_green_factor  = csr_write_data;
            CSR_LUMA_GAIN:        csr_in.luma_gain        = csr_write_data;
            CSR_LUMA_BLACK_LEVEL: csr_in.luma_black_level = csr_write_data;
            default:              csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign quad_in = '{
      luma_top_left:     req_luma_top_left,
      luma_top_right:    req_luma_top_right,
      luma_bottom_left:  req_luma_bottom_left,
      luma_bottom_right: req_luma_bottom_right,
      chroma_red:        req_chroma_red,
      chroma_blue:       req_chroma_blue
   };
   assign in_valid_in = accept;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         quad_ff <= quad_in;
      end
   end

   ycq_chroma u_chroma (
      .chroma_red  (quad_ff.chroma_red),
      .chroma_blue (quad_ff.chroma_blue),
      .csr         (csr_ff),
      .offsets     (offsets)
   );

   assign lane_luma[0] = quad_ff.luma_top_left;
   assign lane_luma[1] = quad_ff.luma_top_right;
   assign lane_luma[2] = quad_ff.luma_bottom_left;
   assign lane_luma[3] = quad_ff.luma_bottom_right;

   for (genvar lane = 0; lane < LANES; lane++) begin : g_lane
      ycq_pixel u_pixel (
         .luma             (lane_luma[lane]),
         .luma_gain        (csr_ff.luma_gain),
         .luma_black_level (csr_ff.luma_black_level),
         .offsets          (offsets),
         .rgb              (rgb_in[lane])
      );
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_red_top_left       = rgb_ff[0].red;
   assign rsp_green_top_left     = rgb_ff[0].green;
   assign rsp_blue_top_left      = rgb_ff[0].blue;
   assign rsp_red_top_right      = rgb_ff[1].red;
   assign rsp_green_top_right    = rgb_ff[1].green;
   assign rsp_blue_top_right     = rgb_ff[1].blue;
   assign rsp_red_bottom_left    = rgb_ff[2].red;
   assign rsp_green_bottom_left  = rgb_ff[2].green;
   assign rsp_blue_bottom_left   = rgb_ff[2].blue;
   assign rsp_red_bottom_right   = rgb_ff[3].red;
   assign rsp_green_bottom_right = rgb_ff[3].green;
   assign rsp_blue_bottom_right  = rgb_ff[3].blue;

endmodule

/* sv/ycq_checker.sv */
// Port level checker for the quad converter, bound to the top level.
// Depends on ycbcr_quad_to_rgb888 for the bind target only.
module ycq_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Every accepted item yields its result once through the input and result registers.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted item produced no result two cycles later");

   // No result is shown without a matching accepted item.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result shown without a matching accepted item");

   // Reset drops whatever was in flight.
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown in the cycle after reset");

   // The block refuses items only while reset is held.
   a_busy_reset: assert property (@(posedge clock)
      busy |-> reset)
      else $error("busy raised outside reset");

endmodule

bind ycbcr_quad_to_rgb888 ycq_checker u_ycq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ycbcr_quad_to_rgb888: drives 2x2 quads, predicts the
// clamped RGB bytes for every item and checks each result field by field.
// Depends on ycq_pkg and the ycbcr_quad_to_rgb888 RTL.
module testbench;
   import ycq_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   // Drain time for the input and result registers of the block, with margin.
   localparam int DRAIN_CYCLES = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HIGH = 3'd7;

   localparam csr_type JPEG_FACTORS  = '{8'd113, 8'd90, 8'd44, 8'd91, 8'd128, 8'd0};
   localparam csr_type BT601_FACTORS = '{8'd129, 8'd102, 8'd25, 8'd52, 8'd149, 8'd16};
   localparam csr_type BT709_FACTORS = '{8'd135, 8'd115, 8'd14, 8'd34, 8'd149, 8'd16};
   localparam csr_type ZERO_FACTORS  = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
   localparam csr_type FULL_FACTORS  = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};

   typedef struct packed {
      rgb_type top_left;
      rgb_type top_right;
      rgb_type bottom_left;
      rgb_type bottom_right;
   } rgb_quad_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [SAMPLE_W-1:0]  req_luma_top_left = '0;
   logic [SAMPLE_W-1:0]  req_luma_top_right = '0;
   logic [SAMPLE_W-1:0]  req_luma_bottom_left = '0;
   logic [SAMPLE_W-1:0]  req_luma_bottom_right = '0;
   logic [SAMPLE_W-1:0]  req_chroma_red = '0;
   logic [SAMPLE_W-1:0]  req_chroma_blue = '0;
   logic                 rsp_valid;
   logic [SAMPLE_W-1:0]  rsp_red_top_left, rsp_green_top_left, rsp_blue_top_left;
   logic [SAMPLE_W-1:0]  rsp_red_top_right, rsp_green_top_right, rsp_blue_top_right;
   logic [SAMPLE_W-1:0]  rsp_red_bottom_left, rsp_green_bottom_left, rsp_blue_bottom_left;
   logic [SAMPLE_W-1:0]  rsp_red_bottom_right, rsp_green_bottom_right, rsp_blue_bottom_right;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SAMPLE_W-1:0]  csr_write_data = '0;

   csr_type      factors = JPEG_FACTORS;
   quad_type     quads_waiting [$];
   quad_type     held_quad;
   rgb_quad_type rgb_due [$];
   rgb_quad_type due_rgb, seen_rgb;
   int           idle_pct = 0;
   int           fault_count = 0;
   int           cycle_count = 0;
   string        field_names [12] = '{
      "red_top_left", "green_top_left", "blue_top_left",
      "red_top_right", "green_top_right", "blue_top_right",
      "red_bottom_left", "green_bottom_left", "blue_bottom_left",
      "red_bottom_right", "green_bottom_right", "blue_bottom_right"};

   ycbcr_quad_to_rgb888 dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_luma_top_left      (req_luma_top_left),
      .req_luma_top_right     (req_luma_top_right),
      .req_luma_bottom_left   (req_luma_bottom_left),
      .req_luma_bottom_right  (req_luma_bottom_right),
      .req_chroma_red         (req_chroma_red),
      .req_chroma_blue        (req_chroma_blue),
      .rsp_valid              (rsp_valid),
      .rsp_red_top_left       (rsp_red_top_left),
      .rsp_green_top_left     (rsp_green_top_left),
      .rsp_blue_top_left      (rsp_blue_top_left),
      .rsp_red_top_right      (rsp_red_top_right),
      .rsp_green_top_right    (rsp_green_top_right),
      .rsp_blue_top_right     (rsp_blue_top_right),
      .rsp_red_bottom_left    (rsp_red_bottom_left),
      .rsp_green_bottom_left  (rsp_green_bottom_left),
      .rsp_blue_bottom_left   (rsp_blue_bottom_left),
      .rsp_red_bottom_right   (rsp_red_bottom_right),
      .rsp_green_bottom_right (rsp_green_bottom_right),
      .rsp_blue_bottom_right  (rsp_blue_bottom_right),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   function automatic logic [SAMPLE_W-1:0] clip_byte(input int sum);
      if (sum < 0) begin
         return 8'd0;
      end else if (sum > 255) begin
         return 8'd255;
      end
      return sum[SAMPLE_W-1:0];
   endfunction

   // Converts one quad with the given factors; >>> on int floors negative values.
   function automatic rgb_quad_type convert_quad(input quad_type q, input csr_type f);
      int           cr, cb, red_off, green_off, blue_off, scaled;
      int           lumas [4];
      rgb_type      pixels [4];
      rgb_quad_type result;
      cr = int'(q.chroma_red) - 128;
      cb = int'(q.chroma_blue) - 128;
      red_off   = (int'(f.cr_red_factor) * cr) >>> CHROMA_SHIFT;
      blue_off  = (int'(f.cb_blue_factor) * cb) >>> CHROMA_SHIFT;
      green_off = (int'(f.cb_green_factor) * cb + int'(f.cr_green_factor) * cr)
                  >>> GREEN_SHIFT;
      lumas = '{int'(q.luma_top_left), int'(q.luma_top_right),
                int'(q.luma_bottom_left), int'(q.luma_bottom_right)};
      for (int k = 0; k < 4; k++) begin
         scaled = (int'(f.luma_gain) * (lumas[k] - int'(f.luma_black_level))) >>> LUMA_SHIFT;
         pixels[k].red   = clip_byte(scaled + red_off);
         pixels[k].green = clip_byte(scaled - green_off);
         pixels[k].blue  = clip_byte(scaled + blue_off);
      end
      result.top_left     = pixels[0];
      result.top_right    = pixels[1];
      result.bottom_left  = pixels[2];
      result.bottom_right = pixels[3];
      return result;
   endfunction

   // Mostly uniform samples, with the rails and the region around a black level
   // weighted up.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int choice;
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
         return 8'd0;
      end else if (choice == 1) begin
         return 8'd255;
      end else if (choice == 2) begin
         return 8'($urandom_range(0, 31));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic csr_type random_factors();
      csr_type f;
      f.cb_blue_factor   = 8'($urandom_range(0, 255));
      f.cr_red_factor    = 8'($urandom_range(0, 255));
      f.cb_green_factor  = 8'($urandom_range(0, 255));
      f.cr_green_factor  = 8'($urandom_range(0, 255));
      f.luma_gain        = 8'($urandom_range(0, 255));
      f.luma_black_level = 8'($urandom_range(0, 255));
      return f;
   endfunction

   task automatic report_fault(input string message);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s", message);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [SAMPLE_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_CB_BLUE_FACTOR:   factors.cb_blue_factor   = data;
         CSR_CR_RED_FACTOR:    factors.cr_red_factor    = data;
         CSR_CB_GREEN_FACTOR:  factors.cb_green_factor  = data;
         CSR_CR_GREEN_FACTOR:  factors.cr_green_factor  = data;
         CSR_LUMA_GAIN:        factors.luma_gain        = data;
         CSR_LUMA_BLACK_LEVEL: factors.luma_black_level = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_factors(input csr_type f);
      write_csr(CSR_CB_BLUE_FACTOR, f.cb_blue_factor);
      write_csr(CSR_CR_RED_FACTOR, f.cr_red_factor);
      write_csr(CSR_CB_GREEN_FACTOR, f.cb_green_factor);
      write_csr(CSR_CR_GREEN_FACTOR, f.cr_green_factor);
      write_csr(CSR_LUMA_GAIN, f.luma_gain);
      write_csr(CSR_LUMA_BLACK_LEVEL, f.luma_black_level);
   endtask

   task automatic queue_quad(input int tl, input int tr, input int bl, input int br,
                             input int cr, input int cb);
      quad_type q;
      q.luma_top_left     = tl[SAMPLE_W-1:0];
      q.luma_top_right    = tr[SAMPLE_W-1:0];
      q.luma_bottom_left  = bl[SAMPLE_W-1:0];
      q.luma_bottom_right = br[SAMPLE_W-1:0];
      q.chroma_red        = cr[SAMPLE_W-1:0];
      q.chroma_blue       = cb[SAMPLE_W-1:0];
      quads_waiting.push_back(q);
   endtask

   task automatic queue_random_quads(input int count);
      for (int n = 0; n < count; n++) begin
         queue_quad(int'(pick_sample()), int'(pick_sample()), int'(pick_sample()),
                    int'(pick_sample()), int'(pick_sample()), int'(pick_sample()));
      end
   endtask

   // Returns once every queued item has been taken and every result has come back.
   task automatic wait_until_idle();
      while (quads_waiting.size() != 0 || start || rgb_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Driver: the prediction is made at the edge that takes the item, so it
   // always sees the factors that the block itself holds.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            rgb_due.push_back(convert_quad(held_quad, factors));
         end
         if (!start || !busy) begin
            if (quads_waiting.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               held_quad = quads_waiting.pop_front();
               req_luma_top_left     <= held_quad.luma_top_left;
               req_luma_top_right    <= held_quad.luma_top_right;
               req_luma_bottom_left  <= held_quad.luma_bottom_left;
               req_luma_bottom_right <= held_quad.luma_bottom_right;
               req_chroma_red        <= held_quad.chroma_red;
               req_chroma_blue       <= held_quad.chroma_blue;
               start                 <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen_rgb = {rsp_red_top_left, rsp_green_top_left, rsp_blue_top_left,
                     rsp_red_top_right, rsp_green_top_right, rsp_blue_top_right,
                     rsp_red_bottom_left, rsp_green_bottom_left, rsp_blue_bottom_left,
                     rsp_red_bottom_right, rsp_green_bottom_right, rsp_blue_bottom_right};
         if (rgb_due.size() == 0) begin
            report_fault($sformatf("result with no item outstanding: %h", seen_rgb));
         end else begin
            due_rgb = rgb_due.pop_front();
            for (int i = 0; i < 12; i++) begin
               if (seen_rgb[95-8*i -: 8] !== due_rgb[95-8*i -: 8]) begin
                  report_fault($sformatf("mismatch on %s: expected %0d, got %0d",
                                         field_names[i], due_rgb[95-8*i -: 8],
                                         seen_rgb[95-8*i -: 8]));
               end
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset factors (full range), no gaps: rails, neutral grey and chroma corners.
      idle_pct = 0;
      queue_quad(0, 0, 0, 0, 128, 128);
      queue_quad(255, 255, 255, 255, 128, 128);
      queue_quad(0, 85, 170, 255, 0, 0);
      queue_quad(0, 85, 170, 255, 255, 255);
      queue_quad(0, 85, 170, 255, 0, 255);
      queue_quad(0, 85, 170, 255, 255, 0);
      queue_quad(255, 255, 255, 255, 255, 255);
      queue_quad(0, 0, 0, 0, 0, 0);
      queue_quad(128, 128, 128, 128, 255, 128);
      queue_quad(128, 128, 128, 128, 128, 0);
      queue_quad(128, 128, 128, 128, 127, 129);
      queue_quad(1, 254, 127, 128, 1, 254);
      queue_quad(170, 85, 170, 85, 85, 170);
      queue_quad(85, 170, 85, 170, 170, 85);
      queue_random_quads(70);
      wait_until_idle();

      // Video range, with luma below the black level. Writes to unmapped
      // indexes must leave the factors alone.
      load_factors(BT601_FACTORS);
      write_csr(CSR_UNMAPPED_LOW, 8'hFF);
      write_csr(CSR_UNMAPPED_HIGH, 8'h00);
      idle_pct = 55;
      queue_quad(0, 15, 16, 17, 128, 128);
      queue_quad(0, 5, 10, 15, 0, 255);
      queue_quad(15, 16, 255, 0, 255, 0);
      queue_random_quads(80);
      wait_until_idle();

      load_factors(BT709_FACTORS);
      idle_pct = 0;
      queue_random_quads(80);
      wait_until_idle();

      load_factors(ZERO_FACTORS);
      idle_pct = 11;
      queue_random_quads(60);
      wait_until_idle();

      load_factors(FULL_FACTORS);
      idle_pct = 55;
      queue_random_quads(60);
      wait_until_idle();

      load_factors(random_factors());
      idle_pct = 11;
      queue_random_quads(70);
      wait_until_idle();

      load_factors(random_factors());
      idle_pct = 0;
      queue_random_quads(70);
      wait_until_idle();

      load_factors(JPEG_FACTORS);
      idle_pct = 55;
      queue_random_quads(60);
      wait_until_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rgb_due.size() != 0) begin
         report_fault($sformatf("%0d results never arrived", rgb_due.size()));
      end
      if (fault_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
